@@ rtl/klsq_pkg.sv @@
// Shared types, widths and codes for the keyed list stack and queue unit.
package klsq_pkg;

    localparam int KLSQ_DEPTH = 16;
    localparam int CMD_W      = 3;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_REMOVE_KEY = 3'd4,
        CMD_SEARCH_KEY = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } t_status;

    // Datapath commands issued by the controller
    typedef enum logic [2:0] {
        DP_NOP   = 3'd0,
        DP_LOAD  = 3'd1,
        DP_EXEC  = 3'd2,
        DP_POP   = 3'd3,
        DP_SCAN  = 3'd4,
        DP_SHIFT = 3'd5,
        DP_EMIT  = 3'd6
    } t_dp_op;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic hit;
        logic walk_end;
        logic out_busy;
    } t_dp_stat;

endpackage

@@ rtl/klsq_ctrl.sv @@
// Request sequencing state machine for the keyed list stack and queue unit.
module klsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  klsq_pkg::t_dp_stat i_stat,
    output klsq_pkg::t_dp_op  o_op
);
    import klsq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_POPW  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_op = DP_EXEC;
                case (i_stat.cmd)
                    CMD_POP_FRONT:  n_state = i_stat.empty ? S_DONE : S_POPW;
                    CMD_REMOVE_KEY: n_state = S_SCAN;
                    CMD_SEARCH_KEY: n_state = S_SCAN;
                    default:        n_state = S_DONE;
                endcase
            end
            S_POPW: begin
                o_op    = DP_POP;
                n_state = S_DONE;
            end
            S_SCAN: begin
                o_op = DP_SCAN;
                if (i_stat.hit) begin
                    n_state = (i_stat.cmd == CMD_REMOVE_KEY) ? S_SHIFT : S_DONE;
                end else if (i_stat.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_op = DP_SHIFT;
                if (i_stat.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_op    = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_search_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.hit && i_stat.cmd == CMD_SEARCH_KEY)
        |=> (r_state == S_DONE))
        else $error("search hit did not finish");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == DP_EMIT) |-> !i_stat.out_busy)
        else $error("result emitted into a busy output register");

endmodule

@@ rtl/klsq_dp.sv @@
// Entry store, pointers, running total and result register.
module klsq_dp #(
    parameter int DEPTH = klsq_pkg::KLSQ_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  klsq_pkg::t_dp_op                  i_op,
    output klsq_pkg::t_dp_stat                o_stat,
    input  logic [klsq_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [klsq_pkg::KEY_W-1:0] i_key,
    input  logic signed [klsq_pkg::VAL_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic signed [klsq_pkg::KEY_W-1:0] o_found_key,
    output logic signed [klsq_pkg::VAL_W-1:0] o_found_value,
    output logic [$clog2(DEPTH+1)-1:0]        o_entry_count,
    output logic signed [klsq_pkg::SUM_W-1:0] o_value_sum
);
    import klsq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] r_mem_key [DEPTH];
    logic [VAL_W-1:0] r_mem_val [DEPTH];

    t_cmd             r_cmd,   n_cmd;
    logic [KEY_W-1:0] r_key,   n_key;
    logic [VAL_W-1:0] r_val,   n_val;
    logic [AW-1:0]    r_head,  n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [SUM_W-1:0] r_total, n_total;
    logic [AW-1:0]    r_ptr,   n_ptr;
    logic [CW-1:0]    r_idx,   n_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [AW-1:0]    r_rd_slot, n_rd_slot;
    logic [AW-1:0]    r_wr_slot, n_wr_slot;
    t_status          r_status, n_status;
    logic [KEY_W-1:0] r_fkey,  n_fkey;
    logic [VAL_W-1:0] r_fval,  n_fval;
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;

    logic             r_out_valid, n_out_valid;
    t_status          r_o_status;
    logic [KEY_W-1:0] r_o_key;
    logic [VAL_W-1:0] r_o_val;
    logic [CW-1:0]    r_o_count;
    logic [SUM_W-1:0] r_o_sum;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_wkey;
    logic [VAL_W-1:0] mem_wval;

    logic             full, empty, hit, walk_end;
    logic [CW:0]      back_sum;
    logic [AW-1:0]    back_slot;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    // Saturating add or subtract of a Q16.16 value into the total
    function automatic logic [SUM_W-1:0] sat_acc(input logic [SUM_W-1:0] t,
                                                 input logic [VAL_W-1:0] v,
                                                 input logic sub);
        logic [SUM_W:0] te;
        logic [SUM_W:0] ve;
        logic [SUM_W:0] s;
        te = {t[SUM_W-1], t};
        ve = {{(SUM_W + 1 - VAL_W){v[VAL_W-1]}}, v};
        s  = sub ? te - ve : te + ve;
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign hit       = r_rd_vld && (r_rd_key == r_key);
    assign walk_end  = !r_rd_vld && (r_idx == r_count);
    assign back_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign back_slot = (back_sum >= (CW+1)'(DEPTH)) ? AW'(back_sum - (CW+1)'(DEPTH))
                                                    : AW'(back_sum);

    assign o_stat.cmd      = r_cmd;
    assign o_stat.full     = full;
    assign o_stat.empty    = empty;
    assign o_stat.hit      = hit;
    assign o_stat.walk_end = walk_end;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_val     = r_val;
        n_head    = r_head;
        n_count   = r_count;
        n_total   = r_total;
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_rd_slot = r_rd_slot;
        n_wr_slot = r_wr_slot;
        n_status  = r_status;
        n_fkey    = r_fkey;
        n_fval    = r_fval;
        mem_we    = 1'b0;
        mem_waddr = r_wr_slot;
        mem_wkey  = r_rd_key;
        mem_wval  = r_rd_val;
        mem_raddr = r_ptr;
        n_out_valid = r_out_valid && !i_out_ready;

        case (i_op)
            DP_LOAD: begin
                n_cmd    = t_cmd'(i_cmd);
                n_key    = i_key;
                n_val    = i_value;
                n_ptr    = r_head;
                n_idx    = '0;
                n_rd_vld = 1'b0;
                n_status = STS_OK;
                n_fkey   = '0;
                n_fval   = '0;
            end
            DP_EXEC: begin
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_head  = '0;
                        n_count = '0;
                        n_total = '0;
                    end
                    CMD_PUSH_FRONT: begin
                        if (full) begin
                            n_status = STS_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = wrap_dec(r_head);
                            mem_wkey  = r_key;
                            mem_wval  = r_val;
                            n_head    = wrap_dec(r_head);
                            n_count   = r_count + CW'(1);
                            n_total   = sat_acc(r_total, r_val, 1'b0);
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (full) begin
                            n_status = STS_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = back_slot;
                            mem_wkey  = r_key;
                            mem_wval  = r_val;
                            n_count   = r_count + CW'(1);
                            n_total   = sat_acc(r_total, r_val, 1'b0);
                        end
                    end
                    CMD_POP_FRONT: begin
                        mem_raddr = r_head;
                        if (empty) begin
                            n_status = STS_MISS;
                        end
                    end
                    default: ;
                endcase
            end
            DP_POP: begin
                n_fkey  = r_rd_key;
                n_fval  = r_rd_val;
                n_head  = wrap_inc(r_head);
                n_count = r_count - CW'(1);
                n_total = sat_acc(r_total, r_rd_val, 1'b1);
            end
            DP_SCAN: begin
                if (hit) begin
                    n_fkey    = r_rd_key;
                    n_fval    = r_rd_val;
                    n_wr_slot = r_rd_slot;
                    n_rd_vld  = 1'b0;
                end else if (r_idx < r_count) begin
                    n_rd_vld  = 1'b1;
                    n_rd_slot = r_ptr;
                    n_ptr     = wrap_inc(r_ptr);
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_rd_vld = 1'b0;
                    if (walk_end) begin
                        n_status = STS_MISS;
                    end
                end
            end
            DP_SHIFT: begin
                // Move each later entry one slot toward the front
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    n_wr_slot = r_rd_slot;
                end
                if (r_idx < r_count) begin
                    n_rd_vld  = 1'b1;
                    n_rd_slot = r_ptr;
                    n_ptr     = wrap_inc(r_ptr);
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (walk_end) begin
                    n_count = r_count - CW'(1);
                    n_total = sat_acc(r_total, r_fval, 1'b1);
                end
            end
            DP_EMIT: begin
                n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_key[mem_waddr] <= mem_wkey;
            r_mem_val[mem_waddr] <= mem_wval;
        end
        r_rd_key <= r_mem_key[mem_raddr];
        r_rd_val <= r_mem_val[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_total     <= n_total;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_idx     <= n_idx;
        r_rd_slot <= n_rd_slot;
        r_wr_slot <= n_wr_slot;
        r_status  <= n_status;
        r_fkey    <= n_fkey;
        r_fval    <= n_fval;
        if (i_op == DP_EMIT) begin
            r_o_status <= r_status;
            r_o_key    <= r_fkey;
            r_o_val    <= r_fval;
            r_o_count  <= r_count;
            r_o_sum    <= r_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found_key   = r_o_key;
    assign o_found_value = r_o_val;
    assign o_entry_count = r_o_count;
    assign o_value_sum   = r_o_sum;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_shift_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_SHIFT && walk_end) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("keyed removal did not drop one entry");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_EXEC && full) |-> !mem_we)
        else $error("write into a full store");

endmodule

@@ rtl/keyed_list_stack_queue_unit.sv @@
// Keyed list stack and queue unit: top level joining controller and datapath.
// Flow: a request is loaded, then executed; remove front then reads the head entry (not
// when empty), keyed search scans from the front to a hit or the end, and keyed removal
// scans likewise, then on a hit shifts every later entry one slot toward the front.
// Throughput: one request at a time; o_in_ready rises together with o_out_valid.
// Synchronous active-low reset empties the store and zeroes count and total.
module keyed_list_stack_queue_unit #(
    parameter int DEPTH = klsq_pkg::KLSQ_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [klsq_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [klsq_pkg::KEY_W-1:0] i_key,
    input  logic signed [klsq_pkg::VAL_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic signed [klsq_pkg::KEY_W-1:0] o_found_key,
    output logic signed [klsq_pkg::VAL_W-1:0] o_found_value,
    output logic [$clog2(DEPTH+1)-1:0]        o_entry_count,
    output logic signed [klsq_pkg::SUM_W-1:0] o_value_sum
);
    import klsq_pkg::*;

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    klsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_op       (dp_op)
    );

    klsq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (dp_op),
        .o_stat        (dp_stat),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .o_value_sum   (o_value_sum)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the keyed list stack and queue unit.
module tb;
    import klsq_pkg::*;

    localparam int         DEPTH        = KLSQ_DEPTH;
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;
    localparam int         RANDOM_ITEMS = 1030;
    localparam int         CALM_TAIL    = 150;
    localparam int         BLOCK_LEN    = 40;
    localparam int         HOLD_AT      = 300;
    localparam int         LONG_HOLD    = 250;
    localparam int         DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int         STALL_LIMIT  = 2000;
    localparam longint     SUM_MAX      = 64'sd549755813887;
    localparam longint     SUM_MIN      = -64'sd549755813888;

    // Shadow of the entry store; predicts one result per request
    class klsq_shadow;
        typedef struct {
            t_status     status;
            logic [31:0] found_key;
            logic [31:0] found_value;
            logic [4:0]  entry_count;
            logic [39:0] value_sum;
        } result_t;

        logic [31:0] shadow_keys[DEPTH];
        logic [31:0] shadow_values[DEPTH];
        int          head;
        int          held;
        longint      total;
        result_t     pending_results[$];
        int          mismatches;
        int          checked;
        int          hits;
        int          misses;
        int          full_rejects;

        function int held_entries();
            return held;
        endfunction

        function logic [31:0] key_at(int pos);
            return shadow_keys[(head + pos) % DEPTH];
        endfunction

        function longint clamp_total(longint t);
            if (t > SUM_MAX) return SUM_MAX;
            if (t < SUM_MIN) return SUM_MIN;
            return t;
        endfunction

        function void note_request(logic [2:0] c, logic [31:0] k, logic [31:0] v);
            result_t r;
            int      pos;
            int      i;
            r.status      = STS_OK;
            r.found_key   = '0;
            r.found_value = '0;
            pos = -1;
            case (c)
                CMD_CLEAR: begin
                    head  = 0;
                    held  = 0;
                    total = 0;
                end
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        r.status = STS_FULL;
                        full_rejects++;
                    end else begin
                        if (c == CMD_PUSH_FRONT) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            shadow_keys[head]   = k;
                            shadow_values[head] = v;
                        end else begin
                            shadow_keys[(head + held) % DEPTH]   = k;
                            shadow_values[(head + held) % DEPTH] = v;
                        end
                        held++;
                        total = clamp_total(total + longint'(signed'(v)));
                    end
                end
                CMD_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = STS_MISS;
                        misses++;
                    end else begin
                        r.found_key   = shadow_keys[head];
                        r.found_value = shadow_values[head];
                        head = (head + 1) % DEPTH;
                        held--;
                        total = clamp_total(total - longint'(signed'(r.found_value)));
                        hits++;
                    end
                end
                CMD_REMOVE_KEY, CMD_SEARCH_KEY: begin
                    for (i = 0; i < held && pos < 0; i++)
                        if (key_at(i) == k) pos = i;
                    if (pos < 0) begin
                        r.status = STS_MISS;
                        misses++;
                    end else begin
                        r.found_key   = key_at(pos);
                        r.found_value = shadow_values[(head + pos) % DEPTH];
                        hits++;
                        if (c == CMD_REMOVE_KEY) begin
                            for (i = pos; i + 1 < held; i++) begin
                                shadow_keys[(head + i) % DEPTH]   = key_at(i + 1);
                                shadow_values[(head + i) % DEPTH] =
                                    shadow_values[(head + i + 1) % DEPTH];
                            end
                            held--;
                            total = clamp_total(total - longint'(signed'(r.found_value)));
                        end
                    end
                end
                default: ;
            endcase
            r.entry_count = held[4:0];
            r.value_sum   = total[39:0];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [39:0] want, logic [39:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] fk, logic [31:0] fv,
                                   logic [4:0] cnt, logic [39:0] sum);
            result_t r;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d count %0d", st, cnt);
                mismatches++;
                return;
            end
            r = pending_results.pop_front();
            checked++;
            compare_field("status", 40'(r.status), 40'(st));
            compare_field("found_key", 40'(r.found_key), 40'(fk));
            compare_field("found_value", 40'(r.found_value), 40'(fv));
            compare_field("entry_count", 40'(r.entry_count), 40'(cnt));
            compare_field("value_sum", r.value_sum, sum);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_cmd;
    logic signed [31:0] i_key;
    logic signed [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic signed [31:0] o_found_key;
    logic signed [31:0] o_found_value;
    logic [4:0]  o_entry_count;
    logic signed [39:0] o_value_sum;

    klsq_shadow store;
    int         requests_in;
    int         quiet_cycles;
    bit         idle_on;
    bit         hold_done;

    keyed_list_stack_queue_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .o_value_sum   (o_value_sum)
    );

    always #6 i_clk = ~i_clk;

    // Entered and left at a falling edge; valid stays high into the next request
    task automatic send_request(input logic [2:0] c, input logic [31:0] k,
                                input logic [31:0] v);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd      = c;
        i_key      = k;
        i_value    = v;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        store.note_request(c, k, v);
        requests_in++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (store.held_entries() > 0 && roll < 45)
            return store.key_at($urandom_range(0, store.held_entries() - 1));
        if (roll < 75) return 32'($urandom_range(0, 7));
        if (roll < 80) return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mode 0 fills, 1 drains, 2 mixes, 3 leans on keyed removal and search
    task automatic random_request(input int mode);
        int         roll;
        int         ins_pct;
        int         pop_pct;
        logic [2:0] c;
        case (mode)
            0:       begin ins_pct = 80; pop_pct = 5;  end
            1:       begin ins_pct = 20; pop_pct = 40; end
            2:       begin ins_pct = 45; pop_pct = 20; end
            default: begin ins_pct = 30; pop_pct = 10; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 2 && mode != 0)
            c = CMD_CLEAR;
        else if (roll < 3)
            c = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
        else if (roll < 3 + ins_pct)
            c = ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (roll < 3 + ins_pct + pop_pct)
            c = CMD_POP_FRONT;
        else
            c = ($urandom_range(0, 1) != 0) ? CMD_REMOVE_KEY : CMD_SEARCH_KEY;
        send_request(c, pick_key(), pick_value());
    endtask

    // Result side: random stalls, plus one long hold so the unit backs up
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && requests_in >= HOLD_AT) begin
                hold_done   = 1'b1;
                i_out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                store.check_result(o_status, o_found_key, o_found_value,
                                   o_entry_count, o_value_sum);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles, %0d results outstanding",
                       quiet_cycles, store.pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int n;
        store        = new();
        requests_in  = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        hold_done    = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_CLEAR;
        i_key        = '0;
        i_value      = '0;
        mode         = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty store, extremes, duplicate keys, middle removal, unused codes
        send_request(CMD_CLEAR, 32'd0, 32'd0);
        send_request(CMD_POP_FRONT, 32'd0, 32'd0);
        send_request(CMD_SEARCH_KEY, 32'd7, 32'd0);
        send_request(CMD_REMOVE_KEY, 32'd7, 32'd0);
        send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(CMD_PUSH_BACK, 32'h8000_0000, 32'h8000_0000);
        send_request(CMD_PUSH_FRONT, 32'd5, 32'h0001_0000);
        send_request(CMD_PUSH_BACK, 32'd5, 32'hFFFF_0000);
        send_request(CMD_PUSH_BACK, 32'd0, 32'd0);
        send_request(CMD_SEARCH_KEY, 32'd5, 32'd0);
        send_request(CMD_REMOVE_KEY, 32'd5, 32'd0);
        send_request(CMD_SEARCH_KEY, 32'd5, 32'd0);
        send_request(CMD_SEARCH_KEY, 32'h8000_0000, 32'd0);
        send_request(CMD_REMOVE_KEY, 32'h8000_0000, 32'd0);
        send_request(CMD_REMOVE_KEY, 32'd123, 32'd0);
        send_request(CMD_POP_FRONT, 32'd0, 32'd0);
        send_request(CMD_UNUSED_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_CLEAR, 32'd0, 32'd0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_LEN == 0) begin
                mode    = (n == 0) ? 0 : $urandom_range(0, 3);
                idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            end
            random_request(mode);
        end
        i_in_valid = 1'b0;

        while (store.pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d results checked: %0d entries returned,",
                 requests_in, store.checked, store.hits);
        $display("%0d empty or not-found misses, %0d inserts refused on a full store.",
                 store.misses, store.full_rejects);
        if (store.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/klsq_pkg.sv
rtl/klsq_ctrl.sv
rtl/klsq_dp.sv
rtl/keyed_list_stack_queue_unit.sv
tb/sv/tb.sv
